### design/sparse_voxel_octree_lookup_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sparse voxel octree lookup block
// Clocked on clk_i, held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SPARSE_VOXEL_OCTREE_LOOKUP_TOP_MACROS_SVH
`define SPARSE_VOXEL_OCTREE_LOOKUP_TOP_MACROS_SVH

// same-cycle implication
`define SVO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SVO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/svo_pkg.sv
// ----------------------------------------------------------------------------
// svo_pkg
// Shared widths, codes and types of the sparse voxel octree lookup block.
// ----------------------------------------------------------------------------
`default_nettype none

package svo_pkg;

  localparam int NODE_W  = 12;               // 4096 nodes
  localparam int SLOT_W  = 3;                // eight children per node
  localparam int ADDR_W  = NODE_W + SLOT_W;  // child word store address
  localparam int WORD_W  = 32;
  localparam int COORD_W = 8;
  localparam int LVL_W   = 4;
  localparam int HALF_W  = 8;                // largest half size is 128
  localparam int SHAMT_W = 3;
  localparam int SUM_W   = WORD_W + 2;       // node index plus signed offset

  localparam logic [LVL_W-1:0] MAX_LEVELS   = 4'd8;
  localparam logic [LVL_W-1:0] LEVELS_RESET = 4'd8;

  // request opcodes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // result status codes
  localparam logic [1:0] ST_WRITE = 2'd0;
  localparam logic [1:0] ST_FOUND = 2'd1;
  localparam logic [1:0] ST_FAIL  = 2'd2;

  // request tdata layout
  localparam int IN_DATA_W  = 72;
  localparam int NODE_LSB   = 0;
  localparam int SLOT_LSB   = 12;
  localparam int LEAF_LSB   = 15;
  localparam int WORD_LSB   = 16;
  localparam int POSX_LSB   = 48;
  localparam int POSY_LSB   = 56;
  localparam int POSZ_LSB   = 64;

  typedef struct packed {
    logic [COORD_W-1:0] z;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } coord_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic              leaf;
    logic [WORD_W-1:0] word;
  } mem_wr_t;

  typedef struct packed {
    logic              leaf;
    logic [WORD_W-1:0] word;
  } mem_rd_t;

endpackage

`default_nettype wire

### design/svo_node_mem.sv
// ----------------------------------------------------------------------------
// svo_node_mem
// Child slot store: one word and its leaf bit per slot, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module svo_node_mem (
  input  wire                         clk_i,
  input  svo_pkg::mem_wr_t            wr_i,
  input  wire                         rd_en_i,
  input  wire  [svo_pkg::ADDR_W-1:0]  rd_addr_i,
  output svo_pkg::mem_rd_t            rd_o
);

  localparam int DEPTH = 1 << svo_pkg::ADDR_W;

  // leaf bit kept beside each word: a write only ever touches its own bit
  svo_pkg::mem_rd_t mem_q [DEPTH];
  svo_pkg::mem_rd_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= '{leaf: wr_i.leaf, word: wr_i.word};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_o = rd_q;

endmodule

`default_nettype wire

### design/svo_oct_unit.sv
// ----------------------------------------------------------------------------
// svo_oct_unit
// One level of descent: octant pick and next cell corner.
// ----------------------------------------------------------------------------
`default_nettype none

module svo_oct_unit (
  input  svo_pkg::coord_t              pos_i,
  input  svo_pkg::coord_t              corner_i,
  input  wire  [svo_pkg::HALF_W-1:0]   half_i,
  output logic [svo_pkg::SLOT_W-1:0]   oct_o,
  output svo_pkg::coord_t              corner_o
);

  logic [svo_pkg::COORD_W:0] mid_x, mid_y, mid_z;

  // pos - corner >= half  <=>  pos >= corner + half (corner never exceeds pos)
  assign mid_x = {1'b0, corner_i.x} + {1'b0, half_i};
  assign mid_y = {1'b0, corner_i.y} + {1'b0, half_i};
  assign mid_z = {1'b0, corner_i.z} + {1'b0, half_i};

  assign oct_o[0] = {1'b0, pos_i.x} >= mid_x;
  assign oct_o[1] = {1'b0, pos_i.y} >= mid_y;
  assign oct_o[2] = {1'b0, pos_i.z} >= mid_z;

  assign corner_o.x = oct_o[0] ? mid_x[svo_pkg::COORD_W-1:0] : corner_i.x;
  assign corner_o.y = oct_o[1] ? mid_y[svo_pkg::COORD_W-1:0] : corner_i.y;
  assign corner_o.z = oct_o[2] ? mid_z[svo_pkg::COORD_W-1:0] : corner_i.z;

endmodule

`default_nettype wire

### design/sparse_voxel_octree_lookup_top.sv
// ----------------------------------------------------------------------------
// sparse_voxel_octree_lookup_top
// Point lookup in a linearised sparse voxel octree, with slot write requests.
// ----------------------------------------------------------------------------
//
//  channel   direction  payload                                    handshake
//  s_axis    in         tuser: opcode; tdata: write / lookup fields tvalid/tready
//  m_axis    out        tuser: status; tdata: voxel_value           tvalid/tready
//  cfg       in         levels (4 bits)                             valid/ready
//
//  A write request's result appears in the cycle after it is taken.
//  A lookup issues its first node read in the cycle it is taken, then
//  walks one tree level per read of the child store, whose single read
//  port sets this pace; it walks at most 8 levels before the result.
//  The request side is held off while a lookup walks or an unread result
//  blocks the output register. No clearing pass: slot store is not reset.
//  Reset is asynchronous, active low; levels comes up as 8.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_voxel_octree_lookup_top (
  input  wire         clk_i,
  input  wire         rst_ni,
  // request: node_index[11:0] child_slot[14:12] is_leaf[15] child_word[47:16]
  //          pos_x[55:48] pos_y[63:56] pos_z[71:64]
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [71:0] s_axis_tdata_i,
  input  wire  [0:0]  s_axis_tuser_i,   // opcode[0]
  // result
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // voxel_value[31:0]
  output logic [1:0]  m_axis_tuser_o,   // status[1:0]
  // configuration
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [3:0]  cfg_data_i        // levels[3:0]
);

  typedef enum logic {
    S_IDLE,
    S_WALK
  } state_e;

  state_e                          state_q;
  logic [svo_pkg::LVL_W-1:0]       levels_q;
  logic [svo_pkg::NODE_W-1:0]      node_q;     // node of the read in flight
  svo_pkg::coord_t                 pos_q;
  svo_pkg::coord_t                 corner_q;
  logic [svo_pkg::HALF_W-1:0]      half_q;     // half size of the next level
  logic [svo_pkg::LVL_W-1:0]       lvl_q;      // levels left after this one
  logic                            out_vld_q;
  logic [1:0]                      out_st_q;
  logic [svo_pkg::WORD_W-1:0]      out_val_q;

  // request fields
  logic                            in_op;
  svo_pkg::coord_t                 in_pos;
  logic                            req_acc, out_pop;

  assign in_op    = s_axis_tuser_i[0];
  assign in_pos.x = s_axis_tdata_i[svo_pkg::POSX_LSB +: svo_pkg::COORD_W];
  assign in_pos.y = s_axis_tdata_i[svo_pkg::POSY_LSB +: svo_pkg::COORD_W];
  assign in_pos.z = s_axis_tdata_i[svo_pkg::POSZ_LSB +: svo_pkg::COORD_W];

  assign out_pop         = out_vld_q && m_axis_tready_i;
  assign s_axis_tready_o = (state_q == S_IDLE) && (!out_vld_q || m_axis_tready_i);
  assign req_acc         = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  // walk depth, saturated
  logic [svo_pkg::LVL_W-1:0]   depth;
  logic [svo_pkg::HALF_W-1:0]  half0;
  logic [svo_pkg::LVL_W-1:0]   depth_m1;

  assign depth    = (levels_q > svo_pkg::MAX_LEVELS) ? svo_pkg::MAX_LEVELS : levels_q;
  assign depth_m1 = depth - 4'd1;
  assign half0    = svo_pkg::HALF_W'(1) << depth_m1[svo_pkg::SHAMT_W-1:0];

  // shared octant unit: first level from the request, later levels from regs
  logic                            idle;
  svo_pkg::coord_t                 ou_pos, ou_corner, ou_corner_nxt;
  logic [svo_pkg::HALF_W-1:0]      ou_half;
  logic [svo_pkg::SLOT_W-1:0]      ou_oct;

  assign idle      = (state_q == S_IDLE);
  assign ou_pos    = idle ? in_pos : pos_q;
  assign ou_corner = idle ? '0 : corner_q;
  assign ou_half   = idle ? half0 : half_q;

  svo_oct_unit u_oct (
    .pos_i    (ou_pos),
    .corner_i (ou_corner),
    .half_i   (ou_half),
    .oct_o    (ou_oct),
    .corner_o (ou_corner_nxt)
  );

  // node step: current node plus the sign-extended relative offset
  svo_pkg::mem_rd_t                rd;
  logic [svo_pkg::SUM_W-1:0]       node_n;
  logic                            node_oor;

  assign node_n   = {{(svo_pkg::SUM_W - svo_pkg::NODE_W){1'b0}}, node_q}
                  + {{(svo_pkg::SUM_W - svo_pkg::WORD_W){rd.word[svo_pkg::WORD_W-1]}}, rd.word};
  assign node_oor = node_n[svo_pkg::SUM_W-1:svo_pkg::NODE_W] != '0;

  // child store ports
  svo_pkg::mem_wr_t                wr;
  logic                            rd_en;
  logic [svo_pkg::ADDR_W-1:0]      rd_addr;
  logic                            lookup_start, walk_go;

  assign lookup_start = req_acc && (in_op == svo_pkg::OP_LOOKUP) && (depth != '0);
  assign walk_go      = (state_q == S_WALK) && !rd.leaf && (lvl_q != '0) && !node_oor;

  assign wr.en   = req_acc && (in_op == svo_pkg::OP_WRITE);
  assign wr.addr = {s_axis_tdata_i[svo_pkg::NODE_LSB +: svo_pkg::NODE_W],
                    s_axis_tdata_i[svo_pkg::SLOT_LSB +: svo_pkg::SLOT_W]};
  assign wr.leaf = s_axis_tdata_i[svo_pkg::LEAF_LSB];
  assign wr.word = s_axis_tdata_i[svo_pkg::WORD_LSB +: svo_pkg::WORD_W];

  assign rd_en   = lookup_start || walk_go;
  assign rd_addr = idle ? {svo_pkg::NODE_W'(0), ou_oct}
                        : {node_n[svo_pkg::NODE_W-1:0], ou_oct};

  svo_node_mem u_mem (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_o      (rd)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      levels_q  <= svo_pkg::LEVELS_RESET;
      node_q    <= '0;
      pos_q     <= '0;
      corner_q  <= '0;
      half_q    <= '0;
      lvl_q     <= '0;
      out_vld_q <= 1'b0;
      out_st_q  <= svo_pkg::ST_WRITE;
      out_val_q <= '0;
    end else begin
      if (out_pop) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        levels_q <= cfg_data_i;
      end
      case (state_q)
        S_IDLE: begin
          if (req_acc) begin
            if (in_op == svo_pkg::OP_WRITE) begin
              out_vld_q <= 1'b1;
              out_st_q  <= svo_pkg::ST_WRITE;
              out_val_q <= '0;
            end else if (depth == '0) begin
              // nothing to walk: no leaf can be met
              out_vld_q <= 1'b1;
              out_st_q  <= svo_pkg::ST_FAIL;
              out_val_q <= '0;
            end else begin
              state_q  <= S_WALK;
              node_q   <= '0;
              pos_q    <= in_pos;
              corner_q <= ou_corner_nxt;
              half_q   <= half0 >> 1;
              lvl_q    <= depth_m1;
            end
          end
        end
        S_WALK: begin
          if (rd.leaf) begin
            state_q   <= S_IDLE;
            out_vld_q <= 1'b1;
            out_st_q  <= svo_pkg::ST_FOUND;
            out_val_q <= rd.word;
          end else if ((lvl_q == '0) || node_oor) begin
            // out of levels, or the next node lies outside the store
            state_q   <= S_IDLE;
            out_vld_q <= 1'b1;
            out_st_q  <= svo_pkg::ST_FAIL;
            out_val_q <= '0;
          end else begin
            node_q   <= node_n[svo_pkg::NODE_W-1:0];
            corner_q <= ou_corner_nxt;
            half_q   <= half_q >> 1;
            lvl_q    <= lvl_q - 4'd1;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = out_st_q;
  assign m_axis_tdata_o  = out_val_q;

endmodule

`default_nettype wire

### design/svo_chk.sv
// ----------------------------------------------------------------------------
// svo_chk
// Port-level checks on the octree lookup block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sparse_voxel_octree_lookup_top_macros.svh"

module svo_chk (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        s_axis_tvalid_i,
  input wire        s_axis_tready_o,
  input wire [0:0]  s_axis_tuser_i,
  input wire        m_axis_tvalid_o,
  input wire        m_axis_tready_i,
  input wire [31:0] m_axis_tdata_o,
  input wire [1:0]  m_axis_tuser_o
);

  logic req_acc;
  assign req_acc = s_axis_tvalid_i && s_axis_tready_o;

  // stalled result holds
  `SVO_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i,
    m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o),
    "result changed while stalled")

  // only a found lookup carries a value
  `SVO_ASSERT_NOW(a_val_zero, m_axis_tvalid_o && (m_axis_tuser_o != svo_pkg::ST_FOUND),
    m_axis_tdata_o == '0, "non-zero value on write or failed lookup")

  // a write request answers in the next cycle with write status
  `SVO_ASSERT_NEXT(a_wr_done, req_acc && (s_axis_tuser_i[0] == svo_pkg::OP_WRITE),
    m_axis_tvalid_o && (m_axis_tuser_o == svo_pkg::ST_WRITE),
    "write request not answered next cycle")

  // a taken lookup blocks new requests while it walks, or fails with no level to walk
  `SVO_ASSERT_NEXT(a_lk_busy, req_acc && (s_axis_tuser_i[0] == svo_pkg::OP_LOOKUP),
    !s_axis_tready_o || (m_axis_tvalid_o && (m_axis_tuser_o == svo_pkg::ST_FAIL)),
    "new request taken during a lookup")

endmodule

bind sparse_voxel_octree_lookup_top svo_chk u_svo_chk (.*);

`default_nettype wire

### tb/sparse_voxel_octree_lookup_top_tb.sv
// ----------------------------------------------------------------------------
// Sparse voxel octree lookup testbench
// Builds octrees through slot write requests and checks every write and
// lookup result against a scoreboard model of the store, across several
// world sizes and with random gaps on both stream sides.
// ----------------------------------------------------------------------------
module sparse_voxel_octree_lookup_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES       = 1 << svo_pkg::NODE_W;
  localparam int STALL_LIMIT = 3000;   // cycles with no handshake at all

  // one request as the scoreboard sees it
  typedef struct packed {
    logic                        op;
    logic [svo_pkg::NODE_W-1:0]  node;
    logic [svo_pkg::SLOT_W-1:0]  slot;
    logic                        leaf;
    logic [svo_pkg::WORD_W-1:0]  word;
    logic [svo_pkg::COORD_W-1:0] x;
    logic [svo_pkg::COORD_W-1:0] y;
    logic [svo_pkg::COORD_W-1:0] z;
  } req_t;

  typedef struct packed {
    logic [1:0]                 status;
    logic [svo_pkg::WORD_W-1:0] value;
  } rsp_t;

  // --------------------------------------------------------------------------
  // DUT signals
  // --------------------------------------------------------------------------
  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_valid = 1'b0;
  logic                          s_axis_tready_o;
  logic [svo_pkg::IN_DATA_W-1:0] s_tdata = '0;
  logic [0:0]                    s_tuser = '0;
  logic                          m_axis_tvalid_o;
  logic                          m_ready = 1'b0;
  logic [31:0]                   m_axis_tdata_o;
  logic [1:0]                    m_axis_tuser_o;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [3:0]                    cfg_data_i = '0;

  sparse_voxel_octree_lookup_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // --------------------------------------------------------------------------
  // Scoreboard state: its own copy of the octree store and of levels.
  // Stores are left unset; the stimulus never reads an unwritten slot.
  // --------------------------------------------------------------------------
  logic [7:0]                 tree_mask [0:NODES-1];
  logic [svo_pkg::WORD_W-1:0] tree_word [0:NODES*8-1];
  logic [svo_pkg::LVL_W-1:0]  walk_levels = svo_pkg::LEVELS_RESET;

  req_t pending_reqs[$];     // requests not yet put on the bus
  rsp_t expected_rsps[$];    // results owed by the block, oldest first
  int   errors = 0;
  bit   quiet = 1'b0;        // phase with no idling on either side

  // stimulus bookkeeping: nodes whose eight slots are all written
  bit node_full [0:NODES-1];
  int built_nodes[$];

  task automatic report_error(input string msg);
    errors++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  // Mostly back to back, now and then a short gap, rarely a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Apply one accepted request to the store and queue the result it owes.
  // A lookup halves the span per level, picks the octant from the offset
  // within the current cube, and follows relative offsets until a leaf,
  // a node outside the store, or the bottom of the walk.
  task automatic resolve_request(input req_t r);
    rsp_t         rsp;
    longint       span;
    longint       ox;
    longint       oy;
    longint       oz;
    longint       at;
    logic [2:0]   oct;
    bit           stop;
    int unsigned  depth;
    rsp.status = svo_pkg::ST_WRITE;
    rsp.value  = '0;
    if (r.op == svo_pkg::OP_WRITE) begin
      tree_mask[r.node][r.slot] = r.leaf;
      tree_word[{r.node, r.slot}] = r.word;
    end else begin
      depth = (walk_levels > svo_pkg::MAX_LEVELS) ? svo_pkg::MAX_LEVELS : walk_levels;
      span = longint'(1) << depth;
      ox = 0;
      oy = 0;
      oz = 0;
      at = 0;
      stop = 1'b0;
      rsp.status = svo_pkg::ST_FAIL;
      while (span > 1 && !stop) begin
        span = span / 2;
        oct[0] = (longint'(r.x) - ox) >= span;
        oct[1] = (longint'(r.y) - oy) >= span;
        oct[2] = (longint'(r.z) - oz) >= span;
        if (at < 0 || at >= NODES) begin
          stop = 1'b1;
        end else if (tree_mask[at][oct]) begin
          rsp.status = svo_pkg::ST_FOUND;
          rsp.value  = tree_word[int'(at) * 8 + int'(oct)];
          stop = 1'b1;
        end else begin
          if (oct[0]) ox += span;
          if (oct[1]) oy += span;
          if (oct[2]) oz += span;
          at += longint'($signed(tree_word[int'(at) * 8 + int'(oct)]));
        end
      end
    end
    expected_rsps.insert(expected_rsps.size(), rsp);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers. Offsets only ever lead to fully written nodes or out
  // of the store, so no walk can touch a slot that was never written.
  // --------------------------------------------------------------------------
  function automatic req_t random_req();
    logic [95:0] raw;
    raw = {$urandom(), $urandom(), $urandom()};
    return raw[$bits(req_t)-1:0];
  endfunction

  task automatic queue_write(input int n, input int s, input logic [32:0] lw);
    req_t r;
    r = random_req();       // lookup fields carry noise
    r.op   = svo_pkg::OP_WRITE;
    r.node = svo_pkg::NODE_W'(n);
    r.slot = svo_pkg::SLOT_W'(s);
    r.leaf = lw[32];
    r.word = lw[31:0];
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  task automatic queue_lookup(input int x, input int y, input int z);
    req_t r;
    r = random_req();       // write fields carry noise
    r.op = svo_pkg::OP_LOOKUP;
    r.x  = svo_pkg::COORD_W'(x);
    r.y  = svo_pkg::COORD_W'(y);
    r.z  = svo_pkg::COORD_W'(z);
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  // {leaf, word} for a slot of node n that keeps every walk on written slots
  function automatic logic [32:0] pick_slot(input int n);
    int unsigned r;
    int          tgt;
    logic [31:0] w;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      case ($urandom_range(0, 7))
        0:       w = 32'h7FFF_FFFF;
        1:       w = 32'h8000_0000;
        2:       w = '0;
        3:       w = '1;
        default: w = $urandom();
      endcase
      return {1'b1, w};
    end
    if (r < 85) begin
      // a few point back at the node itself
      tgt = (r < 40) ? n : built_nodes[$urandom_range(0, built_nodes.size() - 1)];
      return {1'b0, 32'(tgt - n)};
    end
    case ($urandom_range(0, 4))
      0:       w = 32'(-(n + 1) - int'($urandom_range(0, 200)));
      1:       w = 32'(NODES - n + int'($urandom_range(0, 200)));
      2:       w = 32'h8000_0000;
      3:       w = 32'h7FFF_FFFF;
      default: w = {2'b10, 30'($urandom())};   // far below zero
    endcase
    return {1'b0, w};
  endfunction

  task automatic build_node(input int n);
    for (int s = 0; s < 8; s++) queue_write(n, s, pick_slot(n));
    if (!node_full[n]) built_nodes.insert(built_nodes.size(), n);
    node_full[n] = 1'b1;
  endtask

  // Idle means: nothing queued, nothing on the bus, nothing owed.
  // Checked on the falling edge, once every update of the edge has settled.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || s_valid || expected_rsps.size() != 0);
  endtask

  task automatic set_levels(input logic [3:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    walk_levels = v;
    cfg_valid_i <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Request driver: presents the next queued request once the previous one
  // has been taken and its trailing gap has run out.
  // --------------------------------------------------------------------------
  req_t        bus_req;
  int unsigned send_gap;

  always @(posedge clk_i or negedge rst_ni) begin : req_driver
    req_t nxt;
    if (!rst_ni) begin
      s_valid  <= 1'b0;
      send_gap <= 0;
    end else if (!s_valid || s_axis_tready_o) begin
      if (s_valid) resolve_request(bus_req);
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        s_valid  <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        nxt = pending_reqs.pop_front();
        bus_req <= nxt;
        s_tdata <= {nxt.z, nxt.y, nxt.x, nxt.word, nxt.leaf, nxt.slot, nxt.node};
        s_tuser <= nxt.op;
        s_valid <= 1'b1;
        send_gap <= pick_gap();
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure: ready for a cycle, then maybe a stall.
  int unsigned stall_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready    <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      m_ready    <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_ready    <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: each taken result against the oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    rsp_t want;
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      if (expected_rsps.size() == 0) begin
        report_error($sformatf("result with none expected: status %0d value %h",
                               m_axis_tuser_o, m_axis_tdata_o));
      end else begin
        want = expected_rsps.pop_front();
        if (m_axis_tuser_o !== want.status)
          report_error($sformatf("status %0d, expected %0d", m_axis_tuser_o, want.status));
        if (m_axis_tdata_o !== want.value)
          report_error($sformatf("voxel_value %h, expected %h", m_axis_tdata_o, want.value));
      end
    end
  end

  // Watchdog: a run that stops moving is a failure.
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("ERROR @%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("sparse_voxel_octree_lookup_top regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  int unsigned level_plan[$] = '{0, 1, 15, 3, 8, 9, 2, 5, 7, 4, 6};

  initial begin : sequence_ctl
    int phase_items;
    int unsigned r;
    int unsigned lim;
    int n;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed tree at the reset world size: node 0 and node 4095 hold the
    // corner values, a self loop, offsets off both ends of the store and a
    // hop across the whole store and back.
    queue_write(0, 0, {1'b1, 32'h7FFF_FFFF});
    queue_write(0, 1, {1'b1, 32'h8000_0000});
    queue_write(0, 2, {1'b0, 32'h0000_0000});   // self loop
    queue_write(0, 3, {1'b0, 32'hFFFF_FFFF});   // to node -1
    queue_write(0, 4, {1'b0, 32'd4095});        // to the last node
    queue_write(0, 5, {1'b0, 32'h7FFF_FFFF});   // far above the store
    queue_write(0, 6, {1'b0, 32'h8000_0000});   // far below the store
    queue_write(0, 7, {1'b1, 32'h0000_0000});
    queue_write(4095, 0, {1'b0, 32'(-4095)});   // back to node 0
    queue_write(4095, 1, {1'b0, 32'd1});        // just past the store
    queue_write(4095, 2, {1'b1, 32'hFFFF_FFFF});
    queue_write(4095, 3, {1'b1, 32'($urandom())});
    queue_write(4095, 4, {1'b0, 32'h0000_0000});
    queue_write(4095, 5, {1'b1, 32'($urandom())});
    queue_write(4095, 6, {1'b0, 32'(-4095)});
    queue_write(4095, 7, {1'b1, 32'h5555_AAAA});
    node_full[0] = 1'b1;
    node_full[4095] = 1'b1;
    built_nodes.insert(built_nodes.size(), 0);
    built_nodes.insert(built_nodes.size(), 4095);
    queue_lookup(0, 0, 0);
    queue_lookup(128, 0, 0);
    queue_lookup(255, 255, 255);
    queue_lookup(0, 128, 0);
    queue_lookup(128, 128, 0);
    queue_lookup(0, 0, 128);
    queue_lookup(255, 0, 128);
    queue_lookup(0, 255, 255);
    queue_lookup(64, 0, 255);
    wait_idle();

    // Random phases, one per world size. Mostly lookups on the built trees,
    // with new nodes grafted in and single slots rewritten as they go.
    foreach (level_plan[p]) begin
      set_levels(4'(level_plan[p]));
      quiet = ($urandom_range(0, 3) == 0);
      phase_items = 0;
      lim = (level_plan[p] > 8) ? 255 : (1 << level_plan[p]) - 1;
      while (phase_items < 64) begin
        r = $urandom_range(0, 99);
        if (r < 8 && built_nodes.size() < 300) begin
          build_node($urandom_range(0, NODES - 1));
          phase_items += 8;
        end else if (r < 18) begin
          if (r < 13) begin
            n = built_nodes[$urandom_range(0, built_nodes.size() - 1)];
            queue_write(n, $urandom_range(0, 7), pick_slot(n));
          end else begin
            n = $urandom_range(0, NODES - 1);
            // a full node gets a safe slot; any other a partial write (no offset leads there yet)
            if (node_full[n]) queue_write(n, $urandom_range(0, 7), pick_slot(n));
            else queue_write(n, $urandom_range(0, 7), {1'($urandom()), 32'($urandom())});
          end
          phase_items++;
        end else begin
          // half inside the world, half anywhere (outside goes to upper octants)
          if ($urandom_range(0, 1) == 0)
            queue_lookup($urandom_range(0, lim), $urandom_range(0, lim),
                         $urandom_range(0, lim));
          else
            queue_lookup($urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 255));
          phase_items++;
        end
      end
      wait_idle();
    end

    // let any stray result show up before the verdict
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("sparse_voxel_octree_lookup_top regression: pass");
    end else begin
      $display("sparse_voxel_octree_lookup_top regression: fail");
    end
    $finish;
  end

endmodule
